/* rtl/tksi_pkg.sv */
// Shared types and codes for the top-k sorted insert unit.
// No dependencies; used by the cell, the controller and the top level.
package tksi_pkg;

  localparam int DEPTH_DEF         = 64;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  localparam int KEY_W   = 32;
  localparam int PORT_PW = 32;
  localparam int RIDX_W  = 6;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd1;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  // Wavefront that travels down the cell chain, one cell per cycle
  typedef struct packed {
    logic                    active;
    logic                    op;
    logic                    carry;   // a displaced entry is moving down
    logic                    found;   // the new record has been stored
    logic                    hit;     // the read index matched a valid cell
    logic                    batch_last;
    logic [RIDX_W-1:0]       ridx;
    logic signed [KEY_W-1:0] key;
  } wave_t;

  // One result transaction
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PORT_PW-1:0]      payload;
    logic                    entry_valid;
    logic                    kept;
    logic [POS_W-1:0]        position;
    logic [CNT_W-1:0]        count;
    logic                    batch_done;
  } result_t;

endpackage

/* rtl/tksi_cell.sv */
// One list position of the insertion chain: holds an entry and passes the
// wavefront to its neighbor each cycle. Depends on tksi_pkg.
module tksi_cell #(
  parameter int IDX = 0,
  parameter int PW  = 32,
  parameter int CW  = 7,
  parameter int IW  = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            descending,
  input  logic [CW-1:0]   count,
  input  logic [CW-1:0]   cap,
  input  tksi_pkg::wave_t wave_i,
  input  logic [PW-1:0]   pay_i,
  input  logic [IW-1:0]   pos_i,
  output tksi_pkg::wave_t wave_o,
  output logic [PW-1:0]   pay_o,
  output logic [IW-1:0]   pos_o
);
  import tksi_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [IW-1:0] IDX_P = IW'(IDX);

  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [PW-1:0]           pay_r, pay_nxt;
  wave_t                   wave_r, wave_nxt;
  logic [PW-1:0]           wpay_r, wpay_nxt;
  logic [IW-1:0]           wpos_r, wpos_nxt;

  logic valid_c, in_cap, beat, ridx_match;

  assign valid_c    = IDX_C < count;
  assign in_cap     = IDX_C < cap;
  assign beat       = descending ? (wave_i.key > key_r) : (wave_i.key < key_r);
  assign ridx_match = (IDX < (1 << RIDX_W)) && (wave_i.ridx == RIDX_W'(IDX));

  // Act on the passing wavefront
  always_comb begin
    key_nxt  = key_r;
    pay_nxt  = pay_r;
    wave_nxt = wave_i;
    wpay_nxt = pay_i;
    wpos_nxt = pos_i;
    if (wave_i.active) begin
      if (wave_i.op == OP_READ) begin
        if (valid_c && ridx_match) begin
          wave_nxt.hit = 1'b1;
          wave_nxt.key = key_r;
          wpay_nxt     = pay_r;
        end
      end else if (!wave_i.carry) begin
        if (valid_c && beat) begin
          // take the new record, push the old entry down
          key_nxt        = wave_i.key;
          pay_nxt        = pay_i;
          wave_nxt.carry = 1'b1;
          wave_nxt.found = 1'b1;
          wave_nxt.key   = key_r;
          wpay_nxt       = pay_r;
          wpos_nxt       = IDX_P;
        end else if (IDX_C == count && in_cap) begin
          // append at the first free place
          key_nxt        = wave_i.key;
          pay_nxt        = pay_i;
          wave_nxt.found = 1'b1;
          wpos_nxt       = IDX_P;
        end
      end else if (in_cap && IDX_C <= count) begin
        // shift the displaced entry into this place
        key_nxt = wave_i.key;
        pay_nxt = pay_i;
        if (valid_c) begin
          wave_nxt.key = key_r;
          wpay_nxt     = pay_r;
        end
      end
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    pay_r  <= pay_nxt;
    wpay_r <= wpay_nxt;
    wpos_r <= wpos_nxt;
  end

  // Wavefront register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= '0;
    end else begin
      wave_r <= wave_nxt;
    end
  end

  assign wave_o = wave_r;
  assign pay_o  = wpay_r;
  assign pos_o  = wpos_r;

endmodule

/* rtl/tksi_ctrl.sv */
// Controller: configuration registers, entry count, wavefront launch,
// result capture and output register. Depends on tksi_pkg.
module tksi_ctrl #(
  parameter int DEPTH = 64,
  parameter int PW    = 32,
  parameter int CW    = 7,
  parameter int IW    = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic signed [tksi_pkg::KEY_W-1:0] in_key,
  input  logic [tksi_pkg::PORT_PW-1:0]    in_payload,
  input  logic [tksi_pkg::RIDX_W-1:0]     in_read_index,
  input  logic                            in_batch_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tksi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tksi_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            descending,
  output logic [CW-1:0]                   count,
  output logic [CW-1:0]                   cap,
  output tksi_pkg::wave_t                 inj_wave,
  output logic [PW-1:0]                   inj_pay,
  input  tksi_pkg::wave_t                 tail_wave,
  input  logic [PW-1:0]                   tail_pay,
  input  logic [IW-1:0]                   tail_pos,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tksi_pkg::result_t               out_res
);
  import tksi_pkg::*;

  localparam logic [CW-1:0] CAP_RESET = CW'((DEPTH < 64) ? DEPTH : 64);

  state_t           state_r, state_nxt;
  logic             desc_r, desc_nxt;
  logic [CW-1:0]    cap_r, cap_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  wave_t            inj_r, inj_nxt;
  logic [PW-1:0]    inj_pay_r, inj_pay_nxt;
  result_t          hold_r, hold_nxt;
  result_t          out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire, slot_free, load_out;
  logic [6:0]       cap_wr;
  logic [CW-1:0]    cap_eff;

  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign cap_wr    = cfg_data[6:0];

  // Clamp a written capacity into one to DEPTH
  always_comb begin
    if (cap_wr == 7'd0) begin
      cap_eff = CW'(1);
    end else if (int'(cap_wr) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_wr);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_RUN;
      S_RUN:   if (tail_wave.active) state_nxt = S_DRAIN;
      S_DRAIN: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_RUN:   load_out = 1'b0;
      S_DRAIN: load_out = slot_free;
      default: in_ready = 1'b0;
    endcase
  end

  assign cfg_ready = 1'b1;

  // Configuration writes and count update
  always_comb begin
    desc_nxt  = desc_r;
    cap_nxt   = cap_r;
    count_nxt = count_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_DESCENDING) begin
        desc_nxt = cfg_data[0];
      end else if (cfg_index == REG_CAPACITY) begin
        cap_nxt = cap_eff;
        if (count_r > cap_eff) count_nxt = cap_eff;
      end
    end
    if (state_r == S_RUN && tail_wave.active && tail_wave.op == OP_INSERT &&
        count_r < cap_r) begin
      count_nxt = count_r + CW'(1);
    end
  end

  // Launch one wavefront per accepted transaction
  always_comb begin
    inj_nxt     = '0;
    inj_pay_nxt = inj_pay_r;
    if (in_fire) begin
      inj_nxt.active     = 1'b1;
      inj_nxt.op         = in_op;
      inj_nxt.batch_last = in_batch_last;
      inj_nxt.ridx       = in_read_index;
      inj_nxt.key        = in_key;
      inj_pay_nxt        = PW'(in_payload);
    end
  end

  // Capture the result when the wavefront leaves the chain
  always_comb begin
    hold_nxt = hold_r;
    if (state_r == S_RUN && tail_wave.active) begin
      hold_nxt            = '0;
      hold_nxt.batch_done = tail_wave.batch_last;
      if (tail_wave.op == OP_READ) begin
        hold_nxt.count       = CNT_W'(count_r);
        hold_nxt.entry_valid = tail_wave.hit;
        if (tail_wave.hit) begin
          hold_nxt.key     = tail_wave.key;
          hold_nxt.payload = PORT_PW'(tail_pay);
        end
      end else begin
        hold_nxt.count = CNT_W'((count_r < cap_r) ? count_r + CW'(1) : count_r);
        hold_nxt.kept  = tail_wave.found;
        if (tail_wave.found) hold_nxt.position = POS_W'(tail_pos);
      end
    end
  end

  // Output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load_out) begin
      out_nxt       = hold_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      desc_r      <= 1'b1;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      inj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      desc_r      <= desc_nxt;
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      inj_r       <= inj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    inj_pay_r <= inj_pay_nxt;
    hold_r    <= hold_nxt;
    out_r     <= out_nxt;
  end

  assign descending = desc_r;
  assign count      = count_r;
  assign cap        = cap_r;
  assign inj_wave   = inj_r;
  assign inj_pay    = inj_pay_r;
  assign out_valid  = out_valid_r;
  assign out_res    = out_r;

`ifndef ASSERT_OFF
  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("entry count exceeds capacity");

  a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tail_wave.active |-> state_r == S_RUN)
    else $error("wavefront left the chain outside a run");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && tail_wave.active && tail_wave.op == OP_INSERT &&
     count_r < cap_r && !cfg_valid) |=> count_r == $past(count_r) + CW'(1))
    else $error("insert with room did not grow the list");

  a_pos_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_wave.active && tail_wave.op == OP_INSERT && tail_wave.found) |->
      CW'(tail_pos) <= count_r)
    else $error("inserted record landed past the end of the list");
`endif

endmodule

/* rtl/top_k_sorted_insert_unit.sv */
// Top-k sorted insert unit: a chain of DEPTH list cells and its controller.
// One wavefront walks the whole cell chain, one cell per cycle; its result
// then passes the hold register into the output register.
// One transaction at a time: the next input is taken only once the previous
// result is in the output register, and may be taken while it still waits there.
// Reset: synchronous active-low; list empty, descending order, capacity DEPTH capped at 64.
module top_k_sorted_insert_unit #(
  parameter int DEPTH         = tksi_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = tksi_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic signed [tksi_pkg::KEY_W-1:0] in_key,
  input  logic [tksi_pkg::PORT_PW-1:0]      in_payload,
  input  logic [tksi_pkg::RIDX_W-1:0]       in_read_index,
  input  logic                              in_batch_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tksi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tksi_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tksi_pkg::KEY_W-1:0] out_key,
  output logic [tksi_pkg::PORT_PW-1:0]      out_payload,
  output logic                              out_entry_valid,
  output logic                              out_kept,
  output logic [tksi_pkg::POS_W-1:0]        out_position,
  output logic [tksi_pkg::CNT_W-1:0]        out_count,
  output logic                              out_batch_done
);
  import tksi_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  wave_t            chain_w [DEPTH+1];
  logic [PAYLOAD_WIDTH-1:0] chain_p [DEPTH+1];
  logic [IW-1:0]    chain_q [DEPTH+1];
  logic             descending;
  logic [CW-1:0]    count;
  logic [CW-1:0]    cap;
  result_t          res;

  tksi_ctrl #(
    .DEPTH(DEPTH),
    .PW   (PAYLOAD_WIDTH),
    .CW   (CW),
    .IW   (IW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_key       (in_key),
    .in_payload   (in_payload),
    .in_read_index(in_read_index),
    .in_batch_last(in_batch_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .descending   (descending),
    .count        (count),
    .cap          (cap),
    .inj_wave     (chain_w[0]),
    .inj_pay      (chain_p[0]),
    .tail_wave    (chain_w[DEPTH]),
    .tail_pay     (chain_p[DEPTH]),
    .tail_pos     (chain_q[DEPTH]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res      (res)
  );

  assign chain_q[0] = '0;

  // Build the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tksi_cell #(
      .IDX(i),
      .PW (PAYLOAD_WIDTH),
      .CW (CW),
      .IW (IW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .descending(descending),
      .count     (count),
      .cap       (cap),
      .wave_i    (chain_w[i]),
      .pay_i     (chain_p[i]),
      .pos_i     (chain_q[i]),
      .wave_o    (chain_w[i+1]),
      .pay_o     (chain_p[i+1]),
      .pos_o     (chain_q[i+1])
    );
  end

  assign out_key         = res.key;
  assign out_payload     = res.payload;
  assign out_entry_valid = res.entry_valid;
  assign out_kept        = res.kept;
  assign out_position    = res.position;
  assign out_count       = res.count;
  assign out_batch_done  = res.batch_done;

endmodule
